FILE: hdl/one_wire_master_slot_engine_unit_macros.svh
// Assertion macros for the 1-Wire slot engine.
// Needs clk and rst in the scope where a macro is used.
`ifndef ONE_WIRE_MASTER_SLOT_ENGINE_UNIT_MACROS_SVH
`define ONE_WIRE_MASTER_SLOT_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define OWM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define OWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/owm_pkg.sv
// Package for the 1-Wire slot engine: command codes, phase type and bus timing.
// No dependencies.
package owm_pkg;

  // Command codes carried on op
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_RESET = 3'd1;
  localparam logic [2:0] OP_WBIT  = 3'd2;
  localparam logic [2:0] OP_RBIT  = 3'd3;
  localparam logic [2:0] OP_WBYTE = 3'd4;
  localparam logic [2:0] OP_RBYTE = 3'd5;

  // Sequencer phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_RESET = 3'b010,
    PH_SLOT  = 3'b100
  } phase_t;

  // Bus timing in microsecond ticks, counted from the first tick of a sequence
  localparam logic [9:0] RST_LOW_TICKS   = 10'd480;
  localparam logic [9:0] RST_SAMPLE_TICK = 10'd550;
  localparam logic [9:0] RST_LAST_TICK   = 10'd959;
  localparam logic [9:0] SLOT_LAST_TICK  = 10'd69;
  localparam logic [9:0] SHORT_LOW_TICKS = 10'd6;
  localparam logic [9:0] LONG_LOW_TICKS  = 10'd60;
  localparam logic [9:0] RD_SAMPLE_TICK  = 10'd15;

  // Slots per command
  localparam logic [3:0] SLOTS_BIT  = 4'd1;
  localparam logic [3:0] SLOTS_BYTE = 4'd8;

endpackage

FILE: hdl/one_wire_master_slot_engine_unit.sv
// 1-Wire bus master slot engine, one tick transaction in, one result out.
// Depends on owm_pkg and one_wire_master_slot_engine_unit_macros.svh.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------------
//  in      | in_valid / in_ready    | op, data, line_level
//  out     | out_valid / out_ready  | drive_low, busy_res, done_res, presence,
//          |                        | read_value, rejected
//
// One tick transaction per clock while out_ready keeps up; a result passes through
// the input register, then the result register, before it leaves.
// The sequencer state is updated as a tick moves from the input
// register to the result register.
// Synchronous reset clears the sequencer; no clearing pass.
// While out_ready is low the result holds and in_ready falls once the input
// register is also full.
`include "one_wire_master_slot_engine_unit_macros.svh"

module one_wire_master_slot_engine_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] op,
  input  logic [7:0] data,
  input  logic       line_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       drive_low,
  output logic       busy_res,
  output logic       done_res,
  output logic       presence,
  output logic [7:0] read_value,
  output logic       rejected
);

  // Input register
  logic       s1_valid;
  logic [2:0] s1_op;
  logic [7:0] s1_data;
  logic       s1_line;
  logic       s1_advance;

  // Sequencer state
  owm_pkg::phase_t phase, phase_next;
  logic [9:0] tick_count, tick_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [3:0] slots_left, slots_left_next;
  logic [2:0] command_kind, command_kind_next;
  logic       presence_seen, presence_seen_next;
  logic [7:0] read_hold, read_hold_next;

  // Per-tick results
  logic drive_next;
  logic done_next;
  logic rejected_next;

  // Move a tick on when the result register is free or being emptied
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op   <= op;
      s1_data <= data;
      s1_line <= line_level;
    end
  end

  // Tick step: start a command on an idle engine, then run one tick of it
  always_comb begin
    logic            is_cmd;
    logic            is_write;
    logic [9:0]      low_len;
    owm_pkg::phase_t ph;
    logic [9:0]      t;
    logic [7:0]      sb;
    logic [3:0]      sl;
    logic [2:0]      kind;

    is_cmd = (s1_op == owm_pkg::OP_RESET) || (s1_op == owm_pkg::OP_WBIT) ||
             (s1_op == owm_pkg::OP_RBIT)  || (s1_op == owm_pkg::OP_WBYTE) ||
             (s1_op == owm_pkg::OP_RBYTE);

    ph   = phase;
    t    = tick_count;
    sb   = shift_byte;
    sl   = slots_left;
    kind = command_kind;

    presence_seen_next = presence_seen;
    read_hold_next     = read_hold;
    drive_next         = 1'b0;
    done_next          = 1'b0;
    rejected_next      = 1'b0;

    // Begin a command, or flag one that arrives while busy
    if (phase == owm_pkg::PH_IDLE) begin
      if (is_cmd) begin
        t    = '0;
        kind = s1_op;
        if (s1_op == owm_pkg::OP_RESET) begin
          ph = owm_pkg::PH_RESET;
          sl = '0;
        end else begin
          ph = owm_pkg::PH_SLOT;
          if (s1_op == owm_pkg::OP_WBIT) begin
            sb = {7'd0, s1_data[0]};
            sl = owm_pkg::SLOTS_BIT;
          end else if (s1_op == owm_pkg::OP_WBYTE) begin
            sb = s1_data;
            sl = owm_pkg::SLOTS_BYTE;
          end else if (s1_op == owm_pkg::OP_RBIT) begin
            sb = '0;
            sl = owm_pkg::SLOTS_BIT;
          end else begin
            sb = '0;
            sl = owm_pkg::SLOTS_BYTE;
          end
        end
      end
    end else if (is_cmd) begin
      rejected_next = 1'b1;
    end

    is_write = (kind == owm_pkg::OP_WBIT) || (kind == owm_pkg::OP_WBYTE);
    low_len  = sb[0] ? owm_pkg::SHORT_LOW_TICKS : owm_pkg::LONG_LOW_TICKS;

    case (ph)
      owm_pkg::PH_RESET: begin
        drive_next = (t < owm_pkg::RST_LOW_TICKS);
        if (t == owm_pkg::RST_SAMPLE_TICK) begin
          presence_seen_next = !s1_line;
        end
        if (t >= owm_pkg::RST_LAST_TICK) begin
          done_next = 1'b1;
          ph        = owm_pkg::PH_IDLE;
          t         = '0;
        end else begin
          t = t + 10'd1;
        end
      end
      owm_pkg::PH_SLOT: begin
        if (is_write) begin
          drive_next = (t < low_len);
        end else begin
          drive_next = (t < owm_pkg::SHORT_LOW_TICKS);
          if (t == owm_pkg::RD_SAMPLE_TICK) begin
            if (kind == owm_pkg::OP_RBIT) begin
              sb = {7'd0, s1_line};
            end else begin
              sb = {s1_line, sb[7:1]};
            end
          end
        end
        // Close the slot: shift out the sent bit of a write, count down the slots
        if (t >= owm_pkg::SLOT_LAST_TICK) begin
          t = '0;
          if (is_write) begin
            sb = {1'b0, sb[7:1]};
          end
          if (sl > 4'd1) begin
            sl = sl - 4'd1;
          end else begin
            sl = '0;
            if (!is_write) begin
              read_hold_next = sb;
            end
            done_next = 1'b1;
            ph        = owm_pkg::PH_IDLE;
          end
        end else begin
          t = t + 10'd1;
        end
      end
      default: begin
        drive_next = 1'b0;
      end
    endcase

    phase_next        = ph;
    tick_count_next   = t;
    shift_byte_next   = sb;
    slots_left_next   = sl;
    command_kind_next = kind;
  end

  // Sequencer state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= owm_pkg::PH_IDLE;
      tick_count    <= '0;
      shift_byte    <= '0;
      slots_left    <= '0;
      command_kind  <= owm_pkg::OP_TICK;
      presence_seen <= 1'b0;
      read_hold     <= '0;
    end else if (s1_advance) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      shift_byte    <= shift_byte_next;
      slots_left    <= slots_left_next;
      command_kind  <= command_kind_next;
      presence_seen <= presence_seen_next;
      read_hold     <= read_hold_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      drive_low  <= drive_next;
      busy_res   <= (phase_next != owm_pkg::PH_IDLE);
      done_res   <= done_next;
      presence   <= presence_seen_next;
      read_value <= read_hold_next;
      rejected   <= rejected_next;
    end
  end

  // Checks on the sequencer
  `OWM_ASSERT_SAME(a_idle_count_zero, phase == owm_pkg::PH_IDLE, tick_count == 10'd0, "tick count left running while idle")
  `OWM_ASSERT_SAME(a_slots_only_in_slot, phase != owm_pkg::PH_SLOT, slots_left == 4'd0, "slots pending outside a slot sequence")
  `OWM_ASSERT_SAME(a_done_ends_busy, out_valid && done_res, !busy_res, "command done but still busy")
  `OWM_ASSERT_SAME(a_drive_in_sequence, out_valid && drive_low, busy_res || done_res, "bus pulled low with no sequence running")

endmodule

FILE: tb/slot_engine_sb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the 1-Wire slot engine: a tick-accurate predictor and the queue of
// expected results. Depends on owm_pkg for command codes, phase type and bus timing.
package slot_engine_sb_pkg;
  import owm_pkg::*;

  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic       presence;
    logic [7:0] read_value;
    logic       rejected;
  } slot_result_t;

  class slot_engine_scoreboard;
    // Predicted sequencer state
    phase_t     ph;
    logic [9:0] tick_no;
    logic [7:0] shift_reg;
    logic [3:0] slots;
    logic [2:0] kind;
    logic       pres;
    logic [7:0] hold;

    slot_result_t pending[$];
    int errors;
    int checked;

    function new();
      ph        = PH_IDLE;
      tick_no   = '0;
      shift_reg = '0;
      slots     = '0;
      kind      = OP_TICK;
      pres      = 1'b0;
      hold      = '0;
      errors    = 0;
      checked   = 0;
    endfunction

    function int waiting();
      return pending.size();
    endfunction

    // Advance the predictor by one accepted tick transaction and queue its result
    function void note_input(logic [2:0] op, logic [7:0] data, logic bus_in);
      slot_result_t r;
      logic is_cmd;
      logic is_write;
      r = '0;
      is_cmd = (op >= OP_RESET) && (op <= OP_RBYTE);

      // Start a sequence on an idle engine; drop a command while busy
      if (ph == PH_IDLE) begin
        if (is_cmd) begin
          tick_no = '0;
          kind = op;
          if (op == OP_RESET) begin
            ph = PH_RESET;
            slots = '0;
          end else begin
            ph = PH_SLOT;
            case (op)
              OP_WBIT: begin
                shift_reg = {7'd0, data[0]};
                slots = SLOTS_BIT;
              end
              OP_WBYTE: begin
                shift_reg = data;
                slots = SLOTS_BYTE;
              end
              OP_RBIT: begin
                shift_reg = '0;
                slots = SLOTS_BIT;
              end
              default: begin
                shift_reg = '0;
                slots = SLOTS_BYTE;
              end
            endcase
          end
        end
      end else if (is_cmd) begin
        r.rejected = 1'b1;
      end

      is_write = (kind == OP_WBIT) || (kind == OP_WBYTE);

      // Reset pulse: low, release, presence sample, recovery
      if (ph == PH_RESET) begin
        r.drive_low = (tick_no < RST_LOW_TICKS);
        if (tick_no == RST_SAMPLE_TICK) pres = !bus_in;
        if (tick_no >= RST_LAST_TICK) begin
          r.done = 1'b1;
          ph = PH_IDLE;
          tick_no = '0;
        end else begin
          tick_no = tick_no + 10'd1;
        end
      end else if (ph == PH_SLOT) begin
        // Time slot: low length set by the bit for writes, fixed for reads
        if (is_write) begin
          r.drive_low = (tick_no < (shift_reg[0] ? SHORT_LOW_TICKS : LONG_LOW_TICKS));
        end else begin
          r.drive_low = (tick_no < SHORT_LOW_TICKS);
          if (tick_no == RD_SAMPLE_TICK) begin
            if (kind == OP_RBIT) shift_reg = {7'd0, bus_in};
            else shift_reg = {bus_in, shift_reg[7:1]};
          end
        end
        if (tick_no >= SLOT_LAST_TICK) begin
          tick_no = '0;
          if (is_write) shift_reg = shift_reg >> 1;
          if (slots > 4'd1) begin
            slots = slots - 4'd1;
          end else begin
            slots = '0;
            if (!is_write) hold = shift_reg;
            r.done = 1'b1;
            ph = PH_IDLE;
          end
        end else begin
          tick_no = tick_no + 10'd1;
        end
      end

      r.busy = (ph != PH_IDLE);
      r.presence = pres;
      r.read_value = hold;
      pending.push_back(r);
    endfunction

    function void report_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(logic drive_low, logic busy, logic done, logic presence,
                               logic [7:0] read_value, logic rejected);
      slot_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual drive %b busy %b done %b",
                 $time, drive_low, busy, done);
        return;
      end
      want = pending.pop_front();
      checked++;
      report_field("drive_low", {7'd0, want.drive_low}, {7'd0, drive_low});
      report_field("busy_res", {7'd0, want.busy}, {7'd0, busy});
      report_field("done_res", {7'd0, want.done}, {7'd0, done});
      report_field("presence", {7'd0, want.presence}, {7'd0, presence});
      report_field("read_value", want.read_value, read_value);
      report_field("rejected", {7'd0, want.rejected}, {7'd0, rejected});
    endfunction
  endclass

endpackage

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Top-level testbench for the 1-Wire slot engine: drives tick transactions with random
// idling on both channels. Depends on owm_pkg, slot_engine_sb_pkg and the engine RTL.
module tb;
  import owm_pkg::*;
  import slot_engine_sb_pkg::*;

  // Unused op codes, treated by the engine as plain ticks
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  // Tick transactions in the whole run, used to split it into idling thirds
  localparam int PLANNED_ITEMS = 2225;
  localparam int TIMEOUT_NS    = 5000000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] op = OP_TICK;
  logic [7:0] data = 8'h00;
  logic       line_level = 1'b1;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_value;
  logic       rejected;

  int send_idle_pct = 33;
  int recv_stall_pct = 48;
  int items_sent = 0;
  int commands = 0;

  slot_engine_scoreboard sb;

  one_wire_master_slot_engine_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .data       (data),
    .line_level (line_level),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .drive_low  (drive_low),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .presence   (presence),
    .read_value (read_value),
    .rejected   (rejected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall at random according to the current idling mode
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watch both channels; note inputs before checking results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(op, data, line_level);
      if (out_valid && out_ready)
        sb.check_result(drive_low, busy_res, done_res, presence, read_value, rejected);
    end
  end

  // Offer one tick transaction, with a random idle gap first, and hold until taken
  task automatic send_tick(input logic [2:0] o, input logic [7:0] d, input logic b);
    // Idling by thirds: receiver slow, then sender slow, then neither
    if (items_sent >= 2 * PLANNED_ITEMS / 3) begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end else if (items_sent >= PLANNED_ITEMS / 3) begin
      send_idle_pct  = 48;
      recv_stall_pct = 33;
    end
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    op         <= o;
    data       <= d;
    line_level <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Ticks with no command while idle, using all plain-tick codes
  task automatic run_idle(input int n);
    logic [2:0] o;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 2))
        0:       o = OP_TICK;
        1:       o = OP_SPARE_LO;
        default: o = OP_SPARE_HI;
      endcase
      send_tick(o, 8'($urandom), 1'($urandom));
    end
  endtask

  // One whole command: the start item, then ticks to its last one. bus_bits gives the
  // line at each sample tick; other ticks see random levels. noise_pct mixes in random
  // ops, so commands arrive while busy; hit_last puts a command on the final tick.
  task automatic run_command(input logic [2:0] cmd, input logic [7:0] wr,
                             input logic [7:0] bus_bits, input int noise_pct,
                             input bit hit_last);
    int slot_len;
    int len;
    logic [2:0] o;
    logic [7:0] d;
    logic b;
    slot_len = int'(SLOT_LAST_TICK) + 1;
    if (cmd == OP_RESET) len = int'(RST_LAST_TICK) + 1;
    else if (cmd == OP_WBYTE || cmd == OP_RBYTE) len = slot_len * int'(SLOTS_BYTE);
    else len = slot_len * int'(SLOTS_BIT);
    for (int i = 0; i < len; i++) begin
      o = OP_TICK;
      d = 8'($urandom);
      b = 1'($urandom);
      if (i == 0) begin
        o = cmd;
        d = wr;
      end else if (hit_last && i == len - 1) begin
        o = 3'($urandom_range(int'(OP_RESET), int'(OP_RBYTE)));
      end else if ($urandom_range(0, 99) < noise_pct) begin
        o = 3'($urandom);
      end
      if (cmd == OP_RESET) begin
        if (i == int'(RST_SAMPLE_TICK)) b = bus_bits[0];
      end else if (i % slot_len == int'(RD_SAMPLE_TICK)) begin
        b = bus_bits[i / slot_len];
      end
      send_tick(o, d, b);
    end
    commands++;
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Plain ticks on an idle engine, then each command once with random content,
    // commands while busy and on the last tick of a sequence
    send_tick(OP_TICK, 8'h00, 1'b0);
    send_tick(OP_SPARE_LO, 8'hFF, 1'b1);
    send_tick(OP_SPARE_HI, 8'h55, 1'b0);
    run_command(OP_RESET, 8'($urandom), 8'h00, 3, 1'b1);
    run_command(OP_WBIT, 8'hFE, 8'($urandom), 0, 1'b0);
    run_command(OP_RBIT, 8'($urandom), 8'hFF, 10, 1'b1);
    run_command(OP_WBYTE, 8'hA5, 8'($urandom), 3, 1'b1);
    run_command(OP_RBYTE, 8'($urandom), 8'($urandom), 5, 1'b0);
    run_idle(2);

    // Drain the pipeline, then allow a short tail for stray results
    in_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d commands (resets, bit and byte slots) over %0d tick transactions,",
             commands, items_sent);
    $display("with %0d results compared and %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results still expected.", sb.waiting());
    $display("FAIL");
    $finish;
  end

endmodule

FILE: one_wire_master_slot_engine_unit.f
+incdir+hdl
hdl/owm_pkg.sv
hdl/one_wire_master_slot_engine_unit.sv
tb/slot_engine_sb_pkg.sv
tb/tb.sv
